// ----- rtl/core/efp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_pkg
// shared types, constants and helpers of the escape-time fractal pixel block
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int IMAGE_WIDTH   = 1024;
    localparam int IMAGE_HEIGHT  = 1024;
    localparam int FRACTION_BITS = 28;

    localparam int PIX_W   = 10;  // pixel coordinate width
    localparam int DX_W    = 13;  // signed pixel minus half size
    localparam int COMP_W  = 32;  // one complex component
    localparam int STEP_W  = 31;
    localparam int MAP_W   = COMP_W + DX_W;
    localparam int PROD_W  = 2 * COMP_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CNT_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_JULIA_A = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_SHIP    = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_JULIA_B = KIND_W'(4);

    localparam logic signed [SUM_W-1:0] ESC_BOUND = SUM_W'(4) <<< FRACTION_BITS;
    localparam logic signed [SUM_W-1:0] SAT_MAX   = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN   = -SUM_W'(64'sd2147483648);

    // reset values of the configuration registers
    localparam logic [KIND_W-1:0]        RST_KIND    = KIND_W'(1);
    localparam logic [STEP_W-1:0]        RST_STEP    = STEP_W'(1048576);
    localparam logic signed [COMP_W-1:0] RST_OFF_RE  = -32'sd187904819;
    localparam logic [CNT_W-1:0]         RST_LIMIT   = CNT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND     = 3'd0,
        CFG_STEP_RE  = 3'd1,
        CFG_STEP_IM  = 3'd2,
        CFG_OFF_RE   = 3'd3,
        CFG_OFF_IM   = 3'd4,
        CFG_JULIA_RE = 3'd5,
        CFG_JULIA_IM = 3'd6,
        CFG_LIMIT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_INIT,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
        logic signed [COMP_W-1:0] offset_re;
        logic signed [COMP_W-1:0] offset_im;
        logic signed [COMP_W-1:0] julia_re;
        logic signed [COMP_W-1:0] julia_im;
        logic [CNT_W-1:0]         limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic map;
        logic init;
        logic mul;
        logic upd;
    } t_dp_cmd;

    typedef struct packed {
        logic limit_hit;
        logic escape;
    } t_dp_stat;

    function automatic logic signed [COMP_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COMP_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COMP_W-1:0];
        end else begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_ctrl
// sequencer: pixel mapping, then multiply / update steps until escape or limit
// ----------------------------------------------------------------------------
module efp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire efp_pkg::t_dp_stat i_stat,
    output efp_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    efp_pkg::t_state r_state;
    efp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            efp_pkg::ST_IDLE: begin
                if (i_start) n_state = efp_pkg::ST_MAP;
            end
            efp_pkg::ST_MAP:  n_state = efp_pkg::ST_INIT;
            efp_pkg::ST_INIT: n_state = efp_pkg::ST_MUL;
            efp_pkg::ST_MUL: begin
                n_state = i_stat.limit_hit ? efp_pkg::ST_DONE : efp_pkg::ST_UPD;
            end
            efp_pkg::ST_UPD: begin
                n_state = i_stat.escape ? efp_pkg::ST_DONE : efp_pkg::ST_MUL;
            end
            efp_pkg::ST_DONE: n_state = efp_pkg::ST_IDLE;
            default:          n_state = efp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            efp_pkg::ST_IDLE: begin
                o_cmd.load = 1'b1;
                o_busy     = 1'b0;
            end
            efp_pkg::ST_MAP:  o_cmd.map  = 1'b1;
            efp_pkg::ST_INIT: o_cmd.init = 1'b1;
            efp_pkg::ST_MUL:  o_cmd.mul  = 1'b1;
            efp_pkg::ST_UPD:  o_cmd.upd  = 1'b1;
            efp_pkg::ST_DONE: o_done     = 1'b1;
            default:          o_busy     = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/efp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efp_dp
// datapath: pixel to point mapping, z registers, product registers, counter
// ----------------------------------------------------------------------------
module efp_dp (
    input  wire logic                            i_clk,
    input  wire efp_pkg::t_cfg                   i_cfg,
    input  wire efp_pkg::t_dp_cmd                i_cmd,
    input  wire logic [efp_pkg::PIX_W-1:0]       i_pixel_x,
    input  wire logic [efp_pkg::PIX_W-1:0]       i_pixel_y,
    output efp_pkg::t_dp_stat                    o_stat,
    output logic [efp_pkg::CNT_W-1:0]            o_count
);

    localparam int F = efp_pkg::FRACTION_BITS;
    localparam int W = efp_pkg::SUM_W;

    logic signed [efp_pkg::DX_W-1:0]   r_dx, r_dy;
    logic signed [efp_pkg::MAP_W-1:0]  r_map_re, r_map_im;
    logic signed [efp_pkg::COMP_W-1:0] r_re, r_im, r_add_re, r_add_im;
    logic signed [efp_pkg::PROD_W-1:0] r_rr, r_ii, r_ri;
    logic [efp_pkg::CNT_W-1:0]         r_count;

    logic signed [efp_pkg::DX_W-1:0]   n_dx, n_dy;
    logic signed [efp_pkg::COMP_W-1:0] n_c_re, n_c_im, n_re, n_im;
    logic signed [efp_pkg::PROD_W-1:0] n_rr, n_ii, n_ri;
    logic signed [efp_pkg::PROD_W-1:0] sr, si, p_abs, p_sh;
    logic                              julia, ship;

    assign julia = (i_cfg.kind == efp_pkg::KIND_JULIA_A) ||
                   (i_cfg.kind == efp_pkg::KIND_JULIA_B);
    assign ship  = (i_cfg.kind == efp_pkg::KIND_SHIP);

    assign n_dx = $signed({{(efp_pkg::DX_W-efp_pkg::PIX_W){1'b0}}, i_pixel_x})
                - $signed(efp_pkg::DX_W'(efp_pkg::IMAGE_WIDTH / 2));
    assign n_dy = $signed({{(efp_pkg::DX_W-efp_pkg::PIX_W){1'b0}}, i_pixel_y})
                - $signed(efp_pkg::DX_W'(efp_pkg::IMAGE_HEIGHT / 2));

    assign n_c_re = efp_pkg::sat32(W'(r_map_re) + W'(i_cfg.offset_re));
    assign n_c_im = efp_pkg::sat32(W'(r_map_im) + W'(i_cfg.offset_im));

    // 32x32 signed products, operands sign-extended to the product width
    assign n_rr = efp_pkg::PROD_W'(r_re) * efp_pkg::PROD_W'(r_re);
    assign n_ii = efp_pkg::PROD_W'(r_im) * efp_pkg::PROD_W'(r_im);
    assign n_ri = efp_pkg::PROD_W'(r_re) * efp_pkg::PROD_W'(r_im);

    // floor shifts of the registered products
    assign sr    = r_rr >>> F;
    assign si    = r_ii >>> F;
    assign p_abs = (ship && r_ri[efp_pkg::PROD_W-1]) ? -r_ri : r_ri;
    assign p_sh  = p_abs >>> (F - 1);

    assign n_re = efp_pkg::sat32(W'(sr) - W'(si) + W'(r_add_re));
    assign n_im = efp_pkg::sat32(W'(p_sh) + W'(r_add_im));

    assign o_stat.escape    = (W'(sr) + W'(si)) > efp_pkg::ESC_BOUND;
    assign o_stat.limit_hit = (r_count >= i_cfg.limit);
    assign o_count          = r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (i_cmd.map) begin
            r_map_re <= efp_pkg::MAP_W'($signed({1'b0, i_cfg.step_re}))
                      * efp_pkg::MAP_W'(r_dx);
            r_map_im <= efp_pkg::MAP_W'($signed({1'b0, i_cfg.step_im}))
                      * efp_pkg::MAP_W'(r_dy);
        end
        if (i_cmd.init) begin
            r_count <= '0;
            if (julia) begin
                r_re     <= n_c_re;
                r_im     <= n_c_im;
                r_add_re <= i_cfg.julia_re;
                r_add_im <= i_cfg.julia_im;
            end else begin
                r_re     <= '0;
                r_im     <= '0;
                r_add_re <= n_c_re;
                r_add_im <= n_c_im;
            end
        end
        if (i_cmd.mul) begin
            r_rr <= n_rr;
            r_ii <= n_ii;
            r_ri <= n_ri;
        end
        if (i_cmd.upd && !o_stat.escape) begin
            r_re    <= n_re;
            r_im    <= n_im;
            r_count <= r_count + efp_pkg::CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/escape_time_fractal_pixel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// escape-time iteration count of one pixel (mandelbrot, julia, burning ship)
// ----------------------------------------------------------------------------
// usage
//   configuration: write i_cfg_data to register i_cfg_idx on any edge with
//   i_cfg_we high; only while the block is idle (busy low, no result pending)
//   input: a pixel beat is taken on the edge where start is high and busy
//   is low; busy stays high until the result has been shown
//   output: o_iteration_count is valid for exactly one cycle while
//   o_result_valid is high; the receiver cannot stall, so no backpressure
// sequence
//   a mapping state, a state to form c and the start point, then per
//   iteration a multiply state (registered 32x32 products) and an update
//   state (escape test and z update); the loop stops in the multiply state
//   when the limit is reached or in the update state when z escapes, and
//   the next pixel is taken only once the sequencer is back in idle
//   the iteration loop runs through the three product registers
// reset
//   synchronous active-low i_rst_n returns the sequencer to idle and loads
//   the configuration registers with their defaults; no memories to clear
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [efp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [efp_pkg::COMP_W-1:0]        i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [efp_pkg::PIX_W-1:0]         i_pixel_x,
    input  wire logic [efp_pkg::PIX_W-1:0]         i_pixel_y,
    output logic                                   o_result_valid,
    output logic [efp_pkg::CNT_W-1:0]              o_iteration_count
);

    // configuration registers, read directly by the datapath
    efp_pkg::t_cfg     r_cfg;
    efp_pkg::t_dp_cmd  cmd;
    efp_pkg::t_dp_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind      <= efp_pkg::RST_KIND;
            r_cfg.step_re   <= efp_pkg::RST_STEP;
            r_cfg.step_im   <= efp_pkg::RST_STEP;
            r_cfg.offset_re <= efp_pkg::RST_OFF_RE;
            r_cfg.offset_im <= '0;
            r_cfg.julia_re  <= '0;
            r_cfg.julia_im  <= '0;
            r_cfg.limit     <= efp_pkg::RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                efp_pkg::CFG_KIND:     r_cfg.kind      <= i_cfg_data[efp_pkg::KIND_W-1:0];
                efp_pkg::CFG_STEP_RE:  r_cfg.step_re   <= i_cfg_data[efp_pkg::STEP_W-1:0];
                efp_pkg::CFG_STEP_IM:  r_cfg.step_im   <= i_cfg_data[efp_pkg::STEP_W-1:0];
                efp_pkg::CFG_OFF_RE:   r_cfg.offset_re <= $signed(i_cfg_data);
                efp_pkg::CFG_OFF_IM:   r_cfg.offset_im <= $signed(i_cfg_data);
                efp_pkg::CFG_JULIA_RE: r_cfg.julia_re  <= $signed(i_cfg_data);
                efp_pkg::CFG_JULIA_IM: r_cfg.julia_im  <= $signed(i_cfg_data);
                efp_pkg::CFG_LIMIT:    r_cfg.limit     <= i_cfg_data[efp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    efp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_result_valid)
    );

    // mapping, iteration and counter
    efp_dp u_dp (
        .i_clk     (i_clk),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_stat    (stat),
        .o_count   (o_iteration_count)
    );

endmodule
`default_nettype wire
